// ----- src/cit_pkg.sv -----
package cit_pkg;

    localparam int MAX_PARTS = 4;
    localparam int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);
    // weighted sum: terms up to 2^48, one per part, plus sign
    localparam int WSUM_W    = 48 + $clog2(MAX_PARTS) + 2;

    localparam int MASS_W    = 38;
    localparam int QW        = 32;
    localparam int TW        = 48;
    localparam int MQ_W      = 49;          // capped mulq result, 0..2^48
    localparam int MA_W      = 33;          // multiplier a operand
    localparam int MB_W      = 50;          // multiplier b operand, split in two halves
    localparam int SPLIT     = 25;
    localparam int ACC_W     = MA_W + MB_W;

    localparam logic [MQ_W-1:0] MQ_CAP = MQ_W'(49'h1_0000_0000_0000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WSUM,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_DONE,
        S_TERM,
        S_OUT
    } t_state;

    // multiply phases
    localparam logic [1:0] PH_LO   = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // per-part tensor program
    localparam logic [3:0] OP_SQ_X = 4'd0;
    localparam logic [3:0] OP_SQ_Y = 4'd1;
    localparam logic [3:0] OP_SQ_Z = 4'd2;
    localparam logic [3:0] OP_T_XX = 4'd3;
    localparam logic [3:0] OP_T_YY = 4'd4;
    localparam logic [3:0] OP_T_ZZ = 4'd5;
    localparam logic [3:0] OP_C_XY = 4'd6;
    localparam logic [3:0] OP_T_XY = 4'd7;
    localparam logic [3:0] OP_C_XZ = 4'd8;
    localparam logic [3:0] OP_T_XZ = 4'd9;
    localparam logic [3:0] OP_C_YZ = 4'd10;
    localparam logic [3:0] OP_T_YZ = 4'd11;

    localparam logic [4:0] DIV_LAST = 5'd31;

endpackage

// ----- src/compound_inertia_tensor_unit.sv -----
// Compound inertia tensor. Parts are taken one per cycle while busy is low
// (start high); up to MAX_PARTS are kept, later ones are dropped. A part with
// last_part set closes the body: with zero total mass the result strobes the
// next cycle with mass_zero set and all else zero; otherwise busy stays high
// while the stored parts are worked and o_valid pulses once busy is low again.
// The work is done on one shared 33x25 multiplier (each Q16.16 product steps
// through phases LO, HI, ADD, DONE; 3 products per part for the mass-weighted
// offsets, 12 per part for the tensor terms) and a one-bit-per-cycle divider
// for the three centre of mass coordinates. o_valid is high for a single
// cycle only; the receiver cannot stall it.
module compound_inertia_tensor_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_part_mass,
    input  logic signed [31:0]  i_offset_x,
    input  logic signed [31:0]  i_offset_y,
    input  logic signed [31:0]  i_offset_z,
    input  logic signed [31:0]  i_local_xx,
    input  logic signed [31:0]  i_local_yy,
    input  logic signed [31:0]  i_local_zz,
    input  logic signed [31:0]  i_local_xy,
    input  logic signed [31:0]  i_local_xz,
    input  logic signed [31:0]  i_local_yz,
    input  logic                i_last_part,
    output logic                o_valid,
    output logic [37:0]         o_total_mass,
    output logic signed [31:0]  o_com_x,
    output logic signed [31:0]  o_com_y,
    output logic signed [31:0]  o_com_z,
    output logic signed [47:0]  o_inertia_xx,
    output logic signed [47:0]  o_inertia_yy,
    output logic signed [47:0]  o_inertia_zz,
    output logic signed [47:0]  o_inertia_xy,
    output logic signed [47:0]  o_inertia_xz,
    output logic signed [47:0]  o_inertia_yz,
    output logic                o_mass_zero
);

    localparam int NP  = cit_pkg::MAX_PARTS;
    localparam int IW  = cit_pkg::IDX_W;
    localparam int CW  = cit_pkg::CNT_W;
    localparam int WW  = cit_pkg::WSUM_W;
    localparam int MW  = cit_pkg::MASS_W;
    localparam int QW  = cit_pkg::QW;
    localparam int TW  = cit_pkg::TW;
    localparam int RW  = cit_pkg::MQ_W;
    localparam int AW  = cit_pkg::MA_W;
    localparam int BW  = cit_pkg::MB_W;
    localparam int SP  = cit_pkg::SPLIT;
    localparam int CCW = cit_pkg::ACC_W;
    localparam int SW  = TW + 3;

    localparam logic signed [SW-1:0] S48_MAX = SW'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [SW-1:0] S48_MIN = -SW'(49'sh0_8000_0000_0000);

    cit_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx,  n_idx;
    logic [1:0]      r_axis, n_axis;
    logic [3:0]      r_op,   n_op;
    logic [1:0]      r_ph,   n_ph;
    logic [4:0]      r_step, n_step;

    // part stores
    logic [31:0]        r_mass [NP];
    logic signed [31:0] r_off  [NP][3];
    logic signed [31:0] r_loc  [NP][6];

    logic [CW-1:0]        r_cnt;
    logic [MW-1:0]        r_msum;
    logic signed [WW-1:0] r_wsum [3];
    logic signed [TW-1:0] r_tsum [6];
    logic signed [QW-1:0] r_com  [3];

    logic [57:0]    r_prod;
    logic [CCW-1:0] r_acc;
    logic [RW-1:0]  r_sq [3];
    logic [RW-1:0]  r_cr;

    logic [MW-1:0] r_rem;
    logic [31:0]   r_quo;
    logic [15:0]   r_dsh;
    logic          r_ovf;

    logic               r_o_valid;
    logic [37:0]        r_o_mass;
    logic signed [31:0] r_o_com [3];
    logic signed [47:0] r_o_ten [6];
    logic               r_o_zero;

    logic          accept, store_ok, part_last;
    logic [MW-1:0] acc_msum;
    logic [IW-1:0] wr_idx;

    logic [31:0]        m_cur;
    logic signed [31:0] off_row [3];
    logic signed [31:0] loc_row [6];
    logic signed [32:0] d_s  [3];
    logic [32:0]        dmag [3];
    logic [2:0]         d_neg;
    logic signed [31:0] o_sel;
    logic [31:0]        omag;

    logic [AW-1:0]    mul_a;
    logic [BW-1:0]    mul_b;
    logic [SP-1:0]    mul_bh;
    logic [57:0]      mul_p;
    logic [CCW-17:0]  acc_sh;
    logic [RW-1:0]    mq_res;

    logic signed [WW-1:0] w_term;
    logic signed [WW-1:0] wsel;
    logic [WW-1:0]        wmag, whi;
    logic [MW:0]          div_t;
    logic                 div_ge;
    logic [32:0]          com_c;
    logic signed [QW-1:0] com_val;

    logic                 trm_en, trm_pos;
    logic [2:0]           trm_e;
    logic signed [SW-1:0] trm_ext, trm_sum;
    logic signed [TW-1:0] trm_sat;

    assign busy      = (r_state != cit_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign store_ok  = (r_cnt < CW'(NP));
    assign wr_idx    = r_cnt[IW-1:0];
    assign acc_msum  = store_ok ? (r_msum + MW'(i_part_mass)) : r_msum;
    assign part_last = ((CW'(r_idx) + CW'(1)) == r_cnt);

    // ---- operand read for the current part
    always_comb begin
        m_cur   = r_mass[r_idx];
        off_row = r_off[r_idx];
        loc_row = r_loc[r_idx];
        for (int k = 0; k < 3; k++) begin
            d_s[k]   = 33'(off_row[k]) - 33'(r_com[k]);
            d_neg[k] = d_s[k][32];
            dmag[k]  = d_neg[k] ? 33'(-d_s[k]) : 33'(d_s[k]);
        end
        o_sel = off_row[r_axis];
        omag  = o_sel[31] ? 32'(-33'(o_sel)) : 32'(o_sel);
    end

    // ---- shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == cit_pkg::S_WSUM) begin
            mul_a = AW'(m_cur);
            mul_b = BW'(omag);
        end else begin
            case (r_op)
                cit_pkg::OP_SQ_X: begin mul_a = dmag[0]; mul_b = BW'(dmag[0]); end
                cit_pkg::OP_SQ_Y: begin mul_a = dmag[1]; mul_b = BW'(dmag[1]); end
                cit_pkg::OP_SQ_Z: begin mul_a = dmag[2]; mul_b = BW'(dmag[2]); end
                cit_pkg::OP_T_XX: begin
                    mul_a = AW'(m_cur);
                    mul_b = BW'(r_sq[1]) + BW'(r_sq[2]);
                end
                cit_pkg::OP_T_YY: begin
                    mul_a = AW'(m_cur);
                    mul_b = BW'(r_sq[0]) + BW'(r_sq[2]);
                end
                cit_pkg::OP_T_ZZ: begin
                    mul_a = AW'(m_cur);
                    mul_b = BW'(r_sq[0]) + BW'(r_sq[1]);
                end
                cit_pkg::OP_C_XY: begin mul_a = dmag[0]; mul_b = BW'(dmag[1]); end
                cit_pkg::OP_C_XZ: begin mul_a = dmag[0]; mul_b = BW'(dmag[2]); end
                cit_pkg::OP_C_YZ: begin mul_a = dmag[1]; mul_b = BW'(dmag[2]); end
                cit_pkg::OP_T_XY,
                cit_pkg::OP_T_XZ,
                cit_pkg::OP_T_YZ: begin mul_a = AW'(m_cur); mul_b = BW'(r_cr); end
                default: ;
            endcase
        end
        mul_bh = (r_ph == cit_pkg::PH_LO) ? mul_b[SP-1:0] : mul_b[BW-1:SP];
        mul_p  = 58'(mul_a * mul_bh);
        // (a*b) >> 16, capped at 2^48
        acc_sh = r_acc[CCW-1:16];
        mq_res = (acc_sh > (CCW-16)'(cit_pkg::MQ_CAP)) ? cit_pkg::MQ_CAP : acc_sh[RW-1:0];
        w_term = o_sel[31] ? -signed'(WW'(mq_res)) : signed'(WW'(mq_res));
    end

    // ---- tensor entry update
    always_comb begin
        trm_en  = 1'b1;
        trm_pos = 1'b1;
        trm_e   = 3'd0;
        case (r_op)
            cit_pkg::OP_T_XX: trm_e = 3'd0;
            cit_pkg::OP_T_YY: trm_e = 3'd1;
            cit_pkg::OP_T_ZZ: trm_e = 3'd2;
            cit_pkg::OP_T_XY: begin trm_e = 3'd3; trm_pos = d_neg[0] != d_neg[1]; end
            cit_pkg::OP_T_XZ: begin trm_e = 3'd4; trm_pos = d_neg[0] != d_neg[2]; end
            cit_pkg::OP_T_YZ: begin trm_e = 3'd5; trm_pos = d_neg[1] != d_neg[2]; end
            default: trm_en = 1'b0;
        endcase
        trm_ext = signed'(SW'(mq_res));
        trm_sum = SW'(r_tsum[trm_e]) + SW'(loc_row[trm_e])
                + (trm_pos ? trm_ext : -trm_ext);
        if (trm_sum > S48_MAX)
            trm_sat = TW'(S48_MAX);
        else if (trm_sum < S48_MIN)
            trm_sat = TW'(S48_MIN);
        else
            trm_sat = TW'(trm_sum);
    end

    // ---- divider datapath
    always_comb begin
        wsel   = r_wsum[r_axis];
        wmag   = wsel[WW-1] ? WW'(-wsel) : WW'(wsel);
        whi    = wmag >> 16;
        div_t  = {r_rem, r_dsh[15]};
        div_ge = (div_t >= {1'b0, r_msum});
        com_c  = r_ovf ? 33'h0_8000_0000 : {1'b0, r_quo};
        if (wsel[WW-1])
            com_val = (com_c > 33'h0_8000_0000) ? 32'sh8000_0000 : signed'(32'(-com_c));
        else
            com_val = (com_c > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(com_c[31:0]);
    end

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_axis  = r_axis;
        n_op    = r_op;
        n_ph    = r_ph;
        n_step  = r_step;
        unique case (r_state)
            cit_pkg::S_IDLE: begin
                if (accept && i_last_part && (acc_msum != '0)) begin
                    n_state = cit_pkg::S_WSUM;
                    n_idx   = '0;
                    n_axis  = cit_pkg::AX_X;
                    n_ph    = cit_pkg::PH_LO;
                end
            end
            cit_pkg::S_WSUM: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == cit_pkg::PH_DONE) begin
                    if (r_axis == cit_pkg::AX_Z) begin
                        n_axis = cit_pkg::AX_X;
                        if (part_last)
                            n_state = cit_pkg::S_DIV_INIT;
                        else
                            n_idx = r_idx + IW'(1);
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end
            end
            cit_pkg::S_DIV_INIT: begin
                n_state = cit_pkg::S_DIV_STEP;
                n_step  = '0;
            end
            cit_pkg::S_DIV_STEP: begin
                n_step = r_step + 5'd1;
                if (r_step == cit_pkg::DIV_LAST)
                    n_state = cit_pkg::S_DIV_DONE;
            end
            cit_pkg::S_DIV_DONE: begin
                if (r_axis == cit_pkg::AX_Z) begin
                    n_axis  = cit_pkg::AX_X;
                    n_state = cit_pkg::S_TERM;
                    n_idx   = '0;
                    n_op    = cit_pkg::OP_SQ_X;
                    n_ph    = cit_pkg::PH_LO;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = cit_pkg::S_DIV_INIT;
                end
            end
            cit_pkg::S_TERM: begin
                n_ph = r_ph + 2'd1;
                if (r_ph == cit_pkg::PH_DONE) begin
                    if (r_op == cit_pkg::OP_T_YZ) begin
                        n_op = cit_pkg::OP_SQ_X;
                        if (part_last)
                            n_state = cit_pkg::S_OUT;
                        else
                            n_idx = r_idx + IW'(1);
                    end else begin
                        n_op = r_op + 4'd1;
                    end
                end
            end
            cit_pkg::S_OUT: n_state = cit_pkg::S_IDLE;
            default:        n_state = cit_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cit_pkg::S_IDLE;
            r_idx   <= '0;
            r_axis  <= cit_pkg::AX_X;
            r_op    <= cit_pkg::OP_SQ_X;
            r_ph    <= cit_pkg::PH_LO;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_axis  <= n_axis;
            r_op    <= n_op;
            r_ph    <= n_ph;
            r_step  <= n_step;
        end
    end

    // ---- body accumulators and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_msum    <= '0;
            for (int k = 0; k < 3; k++) r_wsum[k] <= '0;
            for (int k = 0; k < 6; k++) r_tsum[k] <= '0;
        end else begin
            r_o_valid <= 1'b0;
            case (r_state)
                cit_pkg::S_IDLE: begin
                    if (accept) begin
                        if (i_last_part && (acc_msum == '0)) begin
                            r_o_valid <= 1'b1;
                            r_cnt     <= '0;
                            r_msum    <= '0;
                            for (int k = 0; k < 3; k++) r_wsum[k] <= '0;
                            for (int k = 0; k < 6; k++) r_tsum[k] <= '0;
                        end else if (store_ok) begin
                            r_cnt  <= r_cnt + CW'(1);
                            r_msum <= acc_msum;
                        end
                    end
                end
                cit_pkg::S_WSUM: begin
                    if (r_ph == cit_pkg::PH_DONE)
                        r_wsum[r_axis] <= r_wsum[r_axis] + w_term;
                end
                cit_pkg::S_TERM: begin
                    if (r_ph == cit_pkg::PH_DONE && trm_en)
                        r_tsum[trm_e] <= trm_sat;
                end
                cit_pkg::S_OUT: begin
                    r_o_valid <= 1'b1;
                    r_cnt     <= '0;
                    r_msum    <= '0;
                    for (int k = 0; k < 3; k++) r_wsum[k] <= '0;
                    for (int k = 0; k < 6; k++) r_tsum[k] <= '0;
                end
                default: ;
            endcase
        end
    end

    // ---- stores, multiplier, divider, output payload
    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            r_mass[wr_idx] <= i_part_mass;
            r_off[wr_idx]  <= '{i_offset_x, i_offset_y, i_offset_z};
            r_loc[wr_idx]  <= '{i_local_xx, i_local_yy, i_local_zz,
                                i_local_xy, i_local_xz, i_local_yz};
        end

        if (r_state == cit_pkg::S_WSUM || r_state == cit_pkg::S_TERM) begin
            case (r_ph)
                cit_pkg::PH_LO: r_prod <= mul_p;
                cit_pkg::PH_HI: begin
                    r_acc  <= CCW'(r_prod);
                    r_prod <= mul_p;
                end
                cit_pkg::PH_ADD: r_acc <= r_acc + (CCW'(r_prod) << SP);
                default: ;
            endcase
        end

        if (r_state == cit_pkg::S_TERM && r_ph == cit_pkg::PH_DONE) begin
            case (r_op)
                cit_pkg::OP_SQ_X: r_sq[0] <= mq_res;
                cit_pkg::OP_SQ_Y: r_sq[1] <= mq_res;
                cit_pkg::OP_SQ_Z: r_sq[2] <= mq_res;
                cit_pkg::OP_C_XY,
                cit_pkg::OP_C_XZ,
                cit_pkg::OP_C_YZ: r_cr <= mq_res;
                default: ;
            endcase
        end

        // top of |W| below the mass means quotient fits 32 bits
        if (r_state == cit_pkg::S_DIV_INIT) begin
            r_ovf <= (whi >= WW'(r_msum));
            r_rem <= MW'(whi);
            r_dsh <= wmag[15:0];
            r_quo <= '0;
        end
        if (r_state == cit_pkg::S_DIV_STEP) begin
            r_rem <= div_ge ? MW'(div_t - {1'b0, r_msum}) : MW'(div_t);
            r_quo <= {r_quo[30:0], div_ge};
            r_dsh <= {r_dsh[14:0], 1'b0};
        end
        if (r_state == cit_pkg::S_DIV_DONE)
            r_com[r_axis] <= com_val;

        if (r_state == cit_pkg::S_IDLE && accept && i_last_part && (acc_msum == '0)) begin
            r_o_mass <= '0;
            r_o_zero <= 1'b1;
            for (int k = 0; k < 3; k++) r_o_com[k] <= '0;
            for (int k = 0; k < 6; k++) r_o_ten[k] <= '0;
        end
        if (r_state == cit_pkg::S_OUT) begin
            r_o_mass <= r_msum;
            r_o_zero <= 1'b0;
            r_o_com  <= r_com;
            r_o_ten  <= r_tsum;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_total_mass = r_o_mass;
    assign o_com_x      = r_o_com[0];
    assign o_com_y      = r_o_com[1];
    assign o_com_z      = r_o_com[2];
    assign o_inertia_xx = r_o_ten[0];
    assign o_inertia_yy = r_o_ten[1];
    assign o_inertia_zz = r_o_ten[2];
    assign o_inertia_xy = r_o_ten[3];
    assign o_inertia_xz = r_o_ten[4];
    assign o_inertia_yz = r_o_ten[5];
    assign o_mass_zero  = r_o_zero;

`ifndef NO_ASSERTIONS
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_last_gives_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_part) |=> (o_valid || busy))
        else $error("last part neither started work nor gave a result");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mass_zero) |-> (o_total_mass == '0 && o_inertia_xx == '0
                                       && o_com_x == '0))
        else $error("zero mass result not cleared");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NP))
        else $error("part count beyond store depth");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cit_pkg::S_TERM || r_state == cit_pkg::S_WSUM)
            |-> (CW'(r_idx) < r_cnt))
        else $error("walk past stored parts");
`endif

endmodule

// ----- sim/compound_inertia_tensor_unit_tb.sv -----
module compound_inertia_tensor_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM    = 1900;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  DRAIN_WAIT  = 400;
    localparam logic [63:0] PROD_CAP = 64'h1_0000_0000_0000;
    localparam longint LIM48_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint LIM48_LO = -64'sh8000_0000_0000;

    typedef struct {
        logic [31:0]        mass;
        logic signed [31:0] ofs [3];
        logic signed [31:0] loc [6];
        logic               last;
    } part_t;

    typedef struct {
        logic [37:0]        total_mass;
        logic signed [31:0] com [3];
        logic signed [47:0] tensor [6];
        logic               mass_zero;
    } body_t;

    typedef struct {
        part_t part;
        bit    typed;
        body_t body;
    } dir_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_part_mass;
    logic signed [31:0] i_offset_x, i_offset_y, i_offset_z;
    logic signed [31:0] i_local_xx, i_local_yy, i_local_zz;
    logic signed [31:0] i_local_xy, i_local_xz, i_local_yz;
    logic               i_last_part;
    logic               o_valid;
    logic [37:0]        o_total_mass;
    logic signed [31:0] o_com_x, o_com_y, o_com_z;
    logic signed [47:0] o_inertia_xx, o_inertia_yy, o_inertia_zz;
    logic signed [47:0] o_inertia_xy, o_inertia_xz, o_inertia_yz;
    logic               o_mass_zero;

    compound_inertia_tensor_unit u_dut (.*);

    // body state mirrored from the block
    logic [31:0] kept_mass [cit_pkg::MAX_PARTS];
    longint      kept_ofs  [3*cit_pkg::MAX_PARTS];
    longint      kept_loc  [6*cit_pkg::MAX_PARTS];
    int          kept_cnt;
    logic [63:0] mass_acc;
    longint      moment_acc [3];
    longint      tensor_acc [6];

    body_t pending_bodies [$];
    int    mismatches;
    int    cycles;
    int    burst_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("compound_inertia_tensor_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 16;
        if (p > {64'd0, PROD_CAP})
            return PROD_CAP;
        return p[63:0];
    endfunction

    function automatic logic [63:0] absval(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > LIM48_HI) return LIM48_HI;
        if (v < LIM48_LO) return LIM48_LO;
        return v;
    endfunction

    function automatic void clear_body();
        kept_cnt = 0;
        mass_acc = '0;
        foreach (moment_acc[k]) moment_acc[k] = 0;
        foreach (tensor_acc[k]) tensor_acc[k] = 0;
    endfunction

    // absorbs one accepted part; returns 1 with the body when it closes
    function automatic bit absorb_part(part_t p, output body_t b);
        longint      com [3];
        longint      d [3];
        logic [63:0] sq [3];
        longint      term [6];
        logic [63:0] w, q, r, c, t;
        int          pa, pb;
        b = '{default: '0};
        if (kept_cnt < cit_pkg::MAX_PARTS) begin
            kept_mass[kept_cnt] = p.mass;
            for (int k = 0; k < 3; k++) begin
                w = qmul(64'(p.mass), absval(longint'(p.ofs[k])));
                kept_ofs[3*kept_cnt + k] = p.ofs[k];
                moment_acc[k] += p.ofs[k] < 0 ? -longint'(w) : longint'(w);
            end
            for (int k = 0; k < 6; k++)
                kept_loc[6*kept_cnt + k] = p.loc[k];
            mass_acc += 64'(p.mass);
            kept_cnt++;
        end
        if (!p.last)
            return 0;
        if (mass_acc == 0) begin
            b.mass_zero = 1'b1;
            clear_body();
            return 1;
        end
        for (int k = 0; k < 3; k++) begin
            w = absval(moment_acc[k]);
            q = w / mass_acc;
            r = w % mass_acc;
            c = (q >= 64'h10000) ? 64'h8000_0000 : (q << 16) + (r << 16) / mass_acc;
            if (moment_acc[k] < 0)
                com[k] = c > 64'h8000_0000 ? -longint'(64'h8000_0000) : -longint'(c);
            else
                com[k] = c > 64'h7FFF_FFFF ? longint'(64'h7FFF_FFFF) : longint'(c);
        end
        for (int i = 0; i < kept_cnt; i++) begin
            for (int k = 0; k < 3; k++) begin
                d[k] = kept_ofs[3*i + k] - com[k];
                sq[k] = qmul(absval(d[k]), absval(d[k]));
            end
            term[0] = qmul(64'(kept_mass[i]), sq[1] + sq[2]);
            term[1] = qmul(64'(kept_mass[i]), sq[0] + sq[2]);
            term[2] = qmul(64'(kept_mass[i]), sq[0] + sq[1]);
            for (int k = 0; k < 3; k++) begin
                pa = (k == 2) ? 1 : 0;
                pb = (k == 0) ? 1 : 2;
                t = qmul(64'(kept_mass[i]), qmul(absval(d[pa]), absval(d[pb])));
                // products of like sign are subtracted
                term[3+k] = ((d[pa] < 0) != (d[pb] < 0)) ? longint'(t) : -longint'(t);
            end
            for (int k = 0; k < 6; k++)
                tensor_acc[k] = clamp48(tensor_acc[k] + kept_loc[6*i + k] + term[k]);
        end
        b.total_mass = mass_acc[37:0];
        for (int k = 0; k < 3; k++) b.com[k] = com[k][31:0];
        for (int k = 0; k < 6; k++) b.tensor[k] = tensor_acc[k][47:0];
        clear_body();
        return 1;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("t=%0t %s: got %h, expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        body_t want;
        if (i_rst_n && o_valid) begin
            if (pending_bodies.size() == 0) begin
                $display("t=%0t result with none pending", $realtime);
                mismatches++;
            end else begin
                want = pending_bodies.pop_front();
                if (o_total_mass !== want.total_mass)
                    report("total_mass", 64'(o_total_mass), 64'(want.total_mass));
                if (o_com_x !== want.com[0]) report("com_x", 64'(o_com_x), 64'(want.com[0]));
                if (o_com_y !== want.com[1]) report("com_y", 64'(o_com_y), 64'(want.com[1]));
                if (o_com_z !== want.com[2]) report("com_z", 64'(o_com_z), 64'(want.com[2]));
                if (o_inertia_xx !== want.tensor[0])
                    report("inertia_xx", 64'(o_inertia_xx), 64'(want.tensor[0]));
                if (o_inertia_yy !== want.tensor[1])
                    report("inertia_yy", 64'(o_inertia_yy), 64'(want.tensor[1]));
                if (o_inertia_zz !== want.tensor[2])
                    report("inertia_zz", 64'(o_inertia_zz), 64'(want.tensor[2]));
                if (o_inertia_xy !== want.tensor[3])
                    report("inertia_xy", 64'(o_inertia_xy), 64'(want.tensor[3]));
                if (o_inertia_xz !== want.tensor[4])
                    report("inertia_xz", 64'(o_inertia_xz), 64'(want.tensor[4]));
                if (o_inertia_yz !== want.tensor[5])
                    report("inertia_yz", 64'(o_inertia_yz), 64'(want.tensor[5]));
                if (o_mass_zero !== want.mass_zero)
                    report("mass_zero", 64'(o_mass_zero), 64'(want.mass_zero));
            end
        end
    end

    // drives one part and holds it until the block takes it
    task automatic send_part(part_t p, bit typed, body_t typed_body);
        body_t b;
        int    gap;
        i_part_mass <= p.mass;
        i_offset_x  <= p.ofs[0];
        i_offset_y  <= p.ofs[1];
        i_offset_z  <= p.ofs[2];
        i_local_xx  <= p.loc[0];
        i_local_yy  <= p.loc[1];
        i_local_zz  <= p.loc[2];
        i_local_xy  <= p.loc[3];
        i_local_xz  <= p.loc[4];
        i_local_yz  <= p.loc[5];
        i_last_part <= p.last;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (absorb_part(p, b))
            pending_bodies.push_back(typed ? typed_body : b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            default: return 32'($signed($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(1, 32'h3_FFFF);
            default: return $urandom_range(1, 32'hFF_FFFF);
        endcase
    endfunction

    function automatic part_t mk(logic [31:0] m, logic [31:0] o, logic [31:0] l, bit last);
        part_t p;
        p.mass = m;
        foreach (p.ofs[k]) p.ofs[k] = (k == 1) ? -o : o;
        foreach (p.loc[k]) p.loc[k] = (k >= 3) ? -l : l;
        p.last = last;
        return p;
    endfunction

    initial begin
        dir_row_t    rows [$];
        dir_row_t    row;
        body_t       none;
        part_t       p;
        int          n, sent;
        bit          no_mass;
        logic [31:0] common_mass;
        int          wait_cycles;

        none = '{default: '0};
        cycles = 0;
        mismatches = 0;
        burst_left = 0;
        clear_body();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_part_mass = '0;
        {i_offset_x, i_offset_y, i_offset_z} = '0;
        {i_local_xx, i_local_yy, i_local_zz} = '0;
        {i_local_xy, i_local_xz, i_local_yz} = '0;
        i_last_part = 1'b0;

        // zero total mass: flag, everything else zero
        row = '{mk(32'h0, 32'h1234_5678, 32'h7FFF_FFFF, 1), 1, none};
        row.body.mass_zero = 1'b1;
        rows.push_back(row);
        // unit mass at the origin: tensor is the local tensor
        row = '{mk(32'h1_0000, 32'h0, 32'h1_0000, 1), 1, none};
        row.body.total_mass = 38'h1_0000;
        foreach (row.body.tensor[k]) row.body.tensor[k] = (k >= 3) ? -48'sh1_0000 : 48'sh1_0000;
        rows.push_back(row);
        // full house at the extremes
        rows.push_back('{mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, none});
        rows.push_back('{mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0), 0, none});
        rows.push_back('{mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0, none});
        rows.push_back('{mk(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1), 0, none});
        // fifth part is dropped but its last flag still closes the body
        for (int j = 0; j < 4; j++)
            rows.push_back('{mk(32'h2_0000 << j, 32'h3_0000 * (j + 1), 32'h1000, 0), 0, none});
        rows.push_back('{mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1), 0, none});
        rows.push_back('{mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1), 0, none});
        // massless parts with offsets
        rows.push_back('{mk(32'h0, 32'h5_0000, 32'h100, 0), 0, none});
        rows.push_back('{mk(32'h0, 32'h8000_0000, 32'h200, 1), 0, none});
        // opposite offsets, mixed signs
        rows.push_back('{mk(32'h1_8000, 32'hFFF0_0000, 32'h4_0000, 0), 0, none});
        rows.push_back('{mk(32'h0_8000, 32'h0010_0000, 32'hFFFC_0000, 1), 0, none});
        rows.push_back('{mk(32'h1, 32'h1, 32'h1, 1), 0, none});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_part(rows[i].part, rows[i].typed, rows[i].body);

        sent = 0;
        while (sent < N_RANDOM) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            no_mass = ($urandom_range(0, 11) == 0);
            common_mass = rand_mass();
            for (int j = 0; j < n; j++) begin
                p.mass = no_mass ? 32'h0 :
                         ($urandom_range(0, 1) ? common_mass : rand_mass());
                foreach (p.ofs[k]) p.ofs[k] = rand_q();
                foreach (p.loc[k]) p.loc[k] = rand_q();
                p.last = (j == n - 1);
                send_part(p, 0, none);
                sent++;
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_bodies.size() != 0 && wait_cycles < 50_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_bodies.size() == 0) begin
            $display("compound_inertia_tensor_unit: match");
        end else begin
            if (pending_bodies.size() != 0)
                $display("%0d results never arrived", pending_bodies.size());
            $display("compound_inertia_tensor_unit: mismatch");
        end
        $finish;
    end

endmodule
